// ===== rtl/core/mxt_pkg.sv =====
package mxt_pkg;

  localparam int VALUE_W = 21;
  localparam int INDEX_W = 11;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] best_xor;
    logic [INDEX_W-1:0] best_start;
    logic [INDEX_W-1:0] best_end;
    logic               improved;
    logic               overflow;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch input word, restart sequence on first
    logic check;       // latch capacity verdict
    logic begin_walk;  // point walk at root, top level
    logic fold;        // fold value into prefix, bump count
    logic ins_step;    // one insert level
    logic ins_zero;    // insert key zero at position zero
    logic qry_step;    // one query level
    logic eval;        // compare against best
    logic emit;        // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic overflow;
    logic empty;
    logic last_level;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/mxt_ctrl.sv =====
module mxt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mxt_pkg::stat_t stat,
  output mxt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ZINS,
    ST_QUERY,
    ST_EVAL,
    ST_INSERT,
    ST_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.overflow) begin
          state_next = ST_EMIT;
        end else if (stat.empty) begin
          cmd.begin_walk = 1'b1;
          state_next     = ST_ZINS;
        end else begin
          cmd.begin_walk = 1'b1;
          cmd.fold       = 1'b1;
          state_next     = ST_QUERY;
        end
      end
      ST_ZINS: begin
        // seed the trie with prefix zero at position zero
        cmd.ins_step = 1'b1;
        cmd.ins_zero = 1'b1;
        if (stat.last_level) begin
          cmd.begin_walk = 1'b1;
          cmd.fold       = 1'b1;
          state_next     = ST_QUERY;
        end
      end
      ST_QUERY: begin
        cmd.qry_step = 1'b1;
        if (stat.last_level) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval       = 1'b1;
        cmd.begin_walk = 1'b1;
        state_next     = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.ins_step = 1'b1;
        if (stat.last_level) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ===== rtl/core/mxt_path.sv =====
module mxt_path #(
  parameter int KEY_BITS   = 21,
  parameter int MAX_ITEMS  = 1024,
  parameter int NODE_COUNT = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  mxt_pkg::in_word_t  in_data,
  input  mxt_pkg::cmd_t      cmd,
  output mxt_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_stall,
  output mxt_pkg::out_word_t out_data
);

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int FW    = $clog2(NODE_COUNT + 1);
  localparam int PW    = $clog2(MAX_ITEMS + 1);
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int CW    = $clog2(NODE_COUNT + 2 * KEY_BITS + 1);
  localparam int XW    = mxt_pkg::VALUE_W;
  localparam int SW    = mxt_pkg::INDEX_W;

  typedef logic [1:0][NW-1:0] links_t;

  // node 0 is the root and lives in root_links; memory entry 0 is unused
  links_t        link_mem [NODE_COUNT];
  logic [PW-1:0] pos_mem  [NODE_COUNT];

  logic [KEY_BITS-1:0] key_in;
  links_t              root_links;
  logic [FW-1:0]       free_node;
  logic [KEY_BITS-1:0] prefix;
  logic [PW-1:0]       count;
  logic [KEY_BITS-1:0] best_value;
  logic [PW-1:0]       best_from;
  logic [PW-1:0]       best_to;
  logic                have_best;
  logic                improved;
  logic                ovf;
  logic [NW-1:0]       cur;
  logic                cur_root;
  logic                fresh;
  logic [LVL_W-1:0]    level;
  logic [KEY_BITS-1:0] x_acc;
  links_t              rd_links;
  logic [PW-1:0]       pos_rd;

  links_t              links_cur;
  logic [KEY_BITS-1:0] ins_key;
  logic [PW-1:0]       ins_pos;
  logic                ins_bit;
  logic [NW-1:0]       ins_exist;
  logic                need_new;
  logic [NW-1:0]       ins_nxt;
  links_t              ins_links;
  logic                q_bit;
  logic                q_hit;
  logic [NW-1:0]       q_nxt;
  logic [NW-1:0]       rd_addr;
  logic                link_we;
  logic [CW-1:0]       need;

  // a freshly allocated node has no children yet, whatever the memory holds
  always_comb begin
    if (cur_root) begin
      links_cur = root_links;
    end else if (fresh) begin
      links_cur = '0;
    end else begin
      links_cur = rd_links;
    end
  end

  always_comb begin
    ins_key   = cmd.ins_zero ? '0 : prefix;
    ins_pos   = cmd.ins_zero ? '0 : count;
    ins_bit   = ins_key[level];
    ins_exist = links_cur[ins_bit];
    need_new  = (ins_exist == '0);
    ins_nxt   = need_new ? free_node[NW-1:0] : ins_exist;
    ins_links = links_cur;
    ins_links[ins_bit] = ins_nxt;

    // prefer the opposite bit
    q_bit = prefix[level];
    q_hit = (links_cur[~q_bit] != '0);
    q_nxt = q_hit ? links_cur[~q_bit] : links_cur[q_bit];

    rd_addr = cmd.qry_step ? q_nxt : ins_nxt;
    link_we = cmd.ins_step && need_new && !cur_root;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cur] <= ins_links;
    end
    if (cmd.ins_step) begin
      pos_mem[ins_nxt] <= ins_pos;
    end
    rd_links <= link_mem[rd_addr];
    pos_rd   <= pos_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_in <= KEY_BITS'(in_data.value);
    end
    if (cmd.ins_step || cmd.qry_step) begin
      cur <= rd_addr;
    end
    if (cmd.qry_step) begin
      x_acc[level] <= q_hit;
    end
    if (cmd.emit) begin
      out_data.best_xor   <= XW'(best_value);
      out_data.best_start <= SW'(best_from);
      out_data.best_end   <= SW'(best_to);
      out_data.improved   <= improved;
      out_data.overflow   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_links <= '0;
      free_node  <= FW'(1);
      prefix     <= '0;
      count      <= '0;
      best_value <= '0;
      best_from  <= '0;
      best_to    <= '0;
      have_best  <= 1'b0;
      improved   <= 1'b0;
      ovf        <= 1'b0;
      cur_root   <= 1'b1;
      fresh      <= 1'b0;
      level      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        improved <= 1'b0;
        ovf      <= 1'b0;
        if (in_data.first) begin
          root_links <= '0;
          free_node  <= FW'(1);
          prefix     <= '0;
          count      <= '0;
          best_value <= '0;
          best_from  <= '0;
          best_to    <= '0;
          have_best  <= 1'b0;
        end
      end
      if (cmd.check) begin
        ovf <= stat.overflow;
      end
      if (cmd.ins_step) begin
        if (need_new) begin
          free_node <= free_node + FW'(1);
          if (cur_root) begin
            root_links <= ins_links;
          end
        end
      end
      // a new walk wins over the step that ends the previous one
      if (cmd.begin_walk) begin
        cur_root <= 1'b1;
        fresh    <= 1'b0;
        level    <= LVL_W'(KEY_BITS - 1);
      end else if (cmd.ins_step) begin
        fresh    <= need_new;
        cur_root <= 1'b0;
        level    <= level - LVL_W'(1);
      end else if (cmd.qry_step) begin
        cur_root <= 1'b0;
        level    <= level - LVL_W'(1);
      end
      if (cmd.fold) begin
        prefix <= prefix ^ key_in;
        count  <= count + PW'(1);
      end
      if (cmd.eval) begin
        // ties keep the earlier best
        if (!have_best || x_acc > best_value) begin
          have_best  <= 1'b1;
          best_value <= x_acc;
          best_from  <= pos_rd + PW'(1);
          best_to    <= count;
          improved   <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a sequence start needs room for the zero prefix as well
  assign need = (count == '0) ? CW'(2 * KEY_BITS) : CW'(KEY_BITS);

  always_comb begin
    stat.overflow   = (count >= PW'(MAX_ITEMS)) ||
                      ((CW'(free_node) + need) > CW'(NODE_COUNT));
    stat.empty      = (count == '0);
    stat.last_level = (level == '0);
    stat.out_free   = !out_valid || !out_stall;
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_node <= FW'(NODE_COUNT))
    else $error("node allocator ran past the end of the trie");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_step && need_new) |-> (free_node < FW'(NODE_COUNT)))
    else $error("node allocated with no free node left");

  a_query_path: assert property (@(posedge clk) disable iff (rst)
    cmd.qry_step |-> (q_nxt != '0))
    else $error("query walk fell off the trie");

  a_best_span: assert property (@(posedge clk) disable iff (rst)
    have_best |-> (best_from != '0 && best_from <= best_to && best_to <= count))
    else $error("best subarray bounds out of order");

  a_emit_word: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result word not presented after emit");

endmodule

// ===== rtl/core/max_xor_subarray_trie_core.sv =====
// Maximum XOR subarray over a stream of values, using a binary trie of prefix XORs.
// Input channel in_valid / in_stall / in_data carries one value and a first flag;
// first clears the trie and the best result before the word is handled.
// Output channel out_valid / out_stall / out_data returns one word per input word:
// the best XOR so far with its 1-based start and end, an improved flag, and an
// overflow flag for a word that was dropped because the sequence or the trie is full.
// Each word walks the trie once for the query and once for the insert, one level
// per cycle against the link memory; a new input word is taken only once the last
// has been handed to the output register. The word that opens a sequence seeds
// prefix zero first with a walk of its own, and a dropped word skips both walks.
// Results wait in an output register: while out_stall holds, the next input word
// is still accepted and processed up to the point of handing over its result.
// Reset clears the sequence state, the root and the allocator; the trie memory
// itself needs no clearing, since nodes are written as they are allocated.
module max_xor_subarray_trie_core #(
  parameter int KEY_BITS   = 21,
  parameter int MAX_ITEMS  = 1024,
  parameter int NODE_COUNT = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mxt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mxt_pkg::out_word_t out_data
);

  mxt_pkg::cmd_t  cmd;
  mxt_pkg::stat_t stat;

  mxt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mxt_path #(
    .KEY_BITS   (KEY_BITS),
    .MAX_ITEMS  (MAX_ITEMS),
    .NODE_COUNT (NODE_COUNT)
  ) u_path (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
